// File: hw/rtl/wss_pkg.sv
// Shared types and constants of the 3D wave stencil step unit.
`default_nettype none

package wss_pkg;

	localparam int FIELD_W   = 32;
	localparam int POS_W     = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 32;
	localparam int DIFF_W    = 34;
	localparam int PROD_W    = 51;
	localparam int SUM_W     = 53;
	localparam int RES_W     = 39;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DIM_X     = 3'd0,
		CFG_DIM_Y     = 3'd1,
		CFG_DIM_Z     = 3'd2,
		CFG_NEIGHBOUR = 3'd3,
		CFG_COEF_X    = 3'd4,
		CFG_COEF_Y    = 3'd5,
		CFG_COEF_Z    = 3'd6
	} cfg_index_t;

	// Face bits of the neighbour mask
	localparam int FACE_NORTH  = 0;
	localparam int FACE_EAST   = 1;
	localparam int FACE_SOUTH  = 2;
	localparam int FACE_WEST   = 3;
	localparam int FACE_TOP    = 4;
	localparam int FACE_BOTTOM = 5;

	typedef struct packed {
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic [POS_W-1:0] pos_z;
		logic             last;
	} pt_tag_t;

	typedef struct packed {
		logic [FIELD_W-1:0] value;
		pt_tag_t            tag;
		logic               sat;
	} out_item_t;

endpackage

`default_nettype wire

// File: hw/rtl/wss_dual_mem.sv
// Plane memory with one write port and two registered read ports.
`default_nettype none

module wss_dual_mem
	import wss_pkg::*;
#(
	parameter int DEPTH = 33800,
	parameter int AW    = 16
) (
	input  wire logic               clk,
	input  wire logic               we,
	input  wire logic [AW-1:0]      wa,
	input  wire logic [FIELD_W-1:0] wd,
	input  wire logic               re,
	input  wire logic [AW-1:0]      raa,
	input  wire logic [AW-1:0]      rab,
	output logic      [FIELD_W-1:0] rda,
	output logic      [FIELD_W-1:0] rdb
);

	logic [FIELD_W-1:0] mem [DEPTH];

	// Read old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rda <= mem[raa];
			rdb <= mem[rab];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/wave_stencil_3d_step_unit.sv
// Top level of the 3D wave stencil step unit (leapfrog, 7-point stencil).
// Usage: write dims, neighbour mask and the Q0.32 coefficients on the cfg
// channel (index 0..6) while idle, then stream one halo-padded block of
// points on s_t* in raster order (x outermost, z fastest). s_tdata carries
// cur_value and prev_value, s_tuser marks the first point of a block.
// Every accepted point at padded x index X may update point (X-1, y, z);
// updates leave on m_t* with the padded position, a saturation flag in
// m_tuser and m_tlast on the final updated point of the block.
// Throughput: one point per clock while s_tready is high. m_tvalid rises after
// the accepting edge through the memory read, differences, split 34x17 products,
// sums, rounding, saturation, then the output register.
// Reset clears position, pipeline valids and registers (dims 128, mask 0,
// coefficients 0); plane memories are not cleared and need no pass.
// When m_tready is low the output register holds, the next update parks in
// a skid register and s_tready drops until the skid register drains.
`default_nettype none

module wave_stencil_3d_step_unit
	import wss_pkg::*;
#(
	parameter int MAX_DIM     = 128,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// [31:0] cur_value, [63:32] prev_value
	input  wire logic [63:0]          s_tdata,
	// [0] block_start
	input  wire logic [0:0]           s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// [31:0] new_value, [39:32] pos_x, [47:40] pos_y, [55:48] pos_z
	output logic [55:0]               m_tdata,
	// [0] saturated
	output logic [0:0]                m_tuser,
	output logic                      m_tlast
);

	localparam int VW    = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
	localparam int SPAN  = MAX_DIM + 2;
	localparam int PLANE = SPAN * SPAN;
	localparam int PW    = $clog2(SPAN + 1);
	localparam int IW    = $clog2(PLANE);
	localparam int AW    = $clog2(2 * PLANE);
	localparam logic signed [RES_W-1:0] SAT_MAX = (RES_W'(1) <<< (VW - 1)) - RES_W'(1);
	localparam logic signed [RES_W-1:0] SAT_MIN = -SAT_MAX - RES_W'(1);

	// ---------------- configuration registers ----------------
	logic [7:0]       dim_x_q, dim_y_q, dim_z_q;
	logic [5:0]       mask_q;
	logic [CFG_W-1:0] coef_x_q, coef_y_q, coef_z_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_x_q  <= 8'd128;
			dim_y_q  <= 8'd128;
			dim_z_q  <= 8'd128;
			mask_q   <= '0;
			coef_x_q <= '0;
			coef_y_q <= '0;
			coef_z_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index_t'(cfg_index))
				CFG_DIM_X:     dim_x_q  <= cfg_data[7:0];
				CFG_DIM_Y:     dim_y_q  <= cfg_data[7:0];
				CFG_DIM_Z:     dim_z_q  <= cfg_data[7:0];
				CFG_NEIGHBOUR: mask_q   <= cfg_data[5:0];
				CFG_COEF_X:    coef_x_q <= cfg_data;
				CFG_COEF_Y:    coef_y_q <= cfg_data;
				CFG_COEF_Z:    coef_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- stage 0: position and addressing ----------------
	logic          skid_v_q;
	logic          en, acc;
	logic [PW-1:0] sx_q, sy_q, sz_q;
	logic [PW-1:0] dx, dy, dz, px, py, pz;
	logic [PW-1:0] x, y, z, i, nx, ny, nz;
	logic [PW-1:0] ib, ie, jb, je, kb, ke;
	logic          start, upd, last;
	logic          bank;
	logic [IW-1:0] idx;
	logic [AW-1:0] own_a, mid_a;
	logic signed [FIELD_W-1:0] cv, pv;

	assign en       = !skid_v_q;
	assign s_tready = en;
	assign acc      = s_tvalid && s_tready;

	// Clamp dims into 1..MAX_DIM
	always_comb begin
		dx = (dim_x_q == 8'd0) ? PW'(1) : (dim_x_q > MAX_DIM) ? PW'(MAX_DIM) : PW'(dim_x_q);
		dy = (dim_y_q == 8'd0) ? PW'(1) : (dim_y_q > MAX_DIM) ? PW'(MAX_DIM) : PW'(dim_y_q);
		dz = (dim_z_q == 8'd0) ? PW'(1) : (dim_z_q > MAX_DIM) ? PW'(MAX_DIM) : PW'(dim_z_q);
		px = dx + PW'(2);
		py = dy + PW'(2);
		pz = dz + PW'(2);
	end

	// Current point, update range and next position
	always_comb begin
		start = s_tuser[0] || sx_q >= px || sy_q >= py || sz_q >= pz;
		x     = start ? '0 : sx_q;
		y     = start ? '0 : sy_q;
		z     = start ? '0 : sz_q;
		i     = x - PW'(1);
		ib    = PW'(2) - PW'(mask_q[FACE_WEST]);
		ie    = dx + PW'(1) - PW'(!mask_q[FACE_EAST]);
		jb    = PW'(2) - PW'(mask_q[FACE_SOUTH]);
		je    = dy + PW'(1) - PW'(!mask_q[FACE_NORTH]);
		kb    = PW'(2) - PW'(mask_q[FACE_BOTTOM]);
		ke    = dz + PW'(1) - PW'(!mask_q[FACE_TOP]);
		upd   = x >= PW'(2) && i >= ib && i < ie && y >= jb && y < je && z >= kb && z < ke;
		last  = i == ie - PW'(1) && y == je - PW'(1) && z == ke - PW'(1);
		bank  = x[0];
		idx   = IW'(y * SPAN + z);
		own_a = bank ? AW'(PLANE) + AW'(idx) : AW'(idx);
		mid_a = bank ? AW'(idx) : AW'(PLANE) + AW'(idx);
		nx = x;
		ny = y;
		nz = z + PW'(1);
		if (nz >= pz) begin
			nz = '0;
			ny = y + PW'(1);
			if (ny >= py) begin
				ny = '0;
				nx = x + PW'(1);
				if (nx >= px) begin
					nx = '0;
				end
			end
		end
		cv = FIELD_W'(signed'(s_tdata[VW-1:0]));
		pv = FIELD_W'(signed'(s_tdata[32+VW-1:32]));
	end

	// Advance the stream position per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q <= '0;
			sy_q <= '0;
			sz_q <= '0;
		end else if (acc) begin
			sx_q <= nx;
			sy_q <= ny;
			sz_q <= nz;
		end
	end

	// ---------------- plane memories ----------------
	logic [FIELD_W-1:0] ym_d, yp_d, zm_d, zp_d, c_d, own_d, p_d;
	logic [FIELD_W-1:0] prev_mem [PLANE];

	wss_dual_mem #(.DEPTH(2 * PLANE), .AW(AW)) u_mem_y (
		.clk(clk), .we(acc), .wa(own_a), .wd(cv), .re(en),
		.raa(mid_a - AW'(SPAN)), .rab(mid_a + AW'(SPAN)), .rda(ym_d), .rdb(yp_d)
	);

	wss_dual_mem #(.DEPTH(2 * PLANE), .AW(AW)) u_mem_z (
		.clk(clk), .we(acc), .wa(own_a), .wd(cv), .re(en),
		.raa(mid_a - AW'(1)), .rab(mid_a + AW'(1)), .rda(zm_d), .rdb(zp_d)
	);

	wss_dual_mem #(.DEPTH(2 * PLANE), .AW(AW)) u_mem_c (
		.clk(clk), .we(acc), .wa(own_a), .wd(cv), .re(en),
		.raa(mid_a), .rab(own_a), .rda(c_d), .rdb(own_d)
	);

	// Previous-level plane, read before overwrite
	always_ff @(posedge clk) begin
		if (acc) begin
			prev_mem[idx] <= pv;
		end
		if (en) begin
			p_d <= prev_mem[idx];
		end
	end

	// ---------------- pipeline ----------------
	logic    v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	pt_tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6;
	logic signed [FIELD_W-1:0] cv_s1;
	logic signed [DIFF_W-1:0]  ddx_s2, ddy_s2, ddz_s2, base_s2, base_s3, base_s4, base_s5;
	logic signed [PROD_W-1:0]  hx_s3, hy_s3, hz_s3, lx_s3, ly_s3, lz_s3;
	logic signed [SUM_W-1:0]   hi_s4, lo_s4;
	logic signed [SUM_W:0]     u;
	logic signed [RES_W-1:0]   t_s5, r;
	logic [FIELD_W-1:0]        val_s6;
	logic                      sat_s6;

	// Hold valids while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= '0;
		end else if (en) begin
			v_s1 <= acc && upd;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_comb begin
		u = (SUM_W + 1)'(hi_s4) + ((SUM_W + 1)'(lo_s4) >>> 16);
		r = RES_W'(base_s5) + t_s5;
	end

	// Differences, split products, sums, rounding, saturation
	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1 <= '{pos_x: POS_W'(i), pos_y: POS_W'(y), pos_z: POS_W'(z), last: last};
			cv_s1  <= cv;

			tag_s2  <= tag_s1;
			ddx_s2  <= DIFF_W'(signed'(own_d)) - (DIFF_W'(signed'(c_d)) <<< 1)
				+ DIFF_W'(cv_s1);
			ddy_s2  <= DIFF_W'(signed'(ym_d)) - (DIFF_W'(signed'(c_d)) <<< 1)
				+ DIFF_W'(signed'(yp_d));
			ddz_s2  <= DIFF_W'(signed'(zm_d)) - (DIFF_W'(signed'(c_d)) <<< 1)
				+ DIFF_W'(signed'(zp_d));
			base_s2 <= (DIFF_W'(signed'(c_d)) <<< 1) - DIFF_W'(signed'(p_d));

			tag_s3  <= tag_s2;
			base_s3 <= base_s2;
			hx_s3   <= PROD_W'(ddx_s2) * PROD_W'(signed'({1'b0, coef_x_q[31:16]}));
			hy_s3   <= PROD_W'(ddy_s2) * PROD_W'(signed'({1'b0, coef_y_q[31:16]}));
			hz_s3   <= PROD_W'(ddz_s2) * PROD_W'(signed'({1'b0, coef_z_q[31:16]}));
			lx_s3   <= PROD_W'(ddx_s2) * PROD_W'(signed'({1'b0, coef_x_q[15:0]}));
			ly_s3   <= PROD_W'(ddy_s2) * PROD_W'(signed'({1'b0, coef_y_q[15:0]}));
			lz_s3   <= PROD_W'(ddz_s2) * PROD_W'(signed'({1'b0, coef_z_q[15:0]}));

			tag_s4  <= tag_s3;
			base_s4 <= base_s3;
			hi_s4   <= SUM_W'(hx_s3) + SUM_W'(hy_s3) + SUM_W'(hz_s3);
			lo_s4   <= SUM_W'(lx_s3) + SUM_W'(ly_s3) + SUM_W'(lz_s3);

			// Round half up after dividing by 2^32
			tag_s5  <= tag_s4;
			base_s5 <= base_s4;
			t_s5    <= RES_W'((u + (SUM_W + 1)'(32768)) >>> 16);

			tag_s6  <= tag_s5;
			if (r > SAT_MAX) begin
				val_s6 <= FIELD_W'(SAT_MAX);
				sat_s6 <= 1'b1;
			end else if (r < SAT_MIN) begin
				val_s6 <= FIELD_W'(SAT_MIN);
				sat_s6 <= 1'b1;
			end else begin
				val_s6 <= FIELD_W'(r);
				sat_s6 <= 1'b0;
			end
		end
	end

	// ---------------- output register and skid ----------------
	logic      o_v_q, o_free;
	out_item_t o_q, skid_q, item_s6;

	assign o_free  = !o_v_q || m_tready;
	assign item_s6 = '{value: val_s6, tag: tag_s6, sat: sat_s6};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q    <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (o_free) begin
				o_v_q    <= 1'b1;
				skid_v_q <= 1'b0;
			end
		end else if (o_free) begin
			o_v_q <= v_s6;
		end else if (v_s6) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (o_free) begin
				o_q <= skid_q;
			end
		end else if (o_free) begin
			o_q <= item_s6;
		end else begin
			skid_q <= item_s6;
		end
	end

	assign m_tvalid   = o_v_q;
	assign m_tdata    = {o_q.tag.pos_z, o_q.tag.pos_y, o_q.tag.pos_x, o_q.value};
	assign m_tuser[0] = o_q.sat;
	assign m_tlast    = o_q.tag.last;

endmodule

`default_nettype wire
